>>> src/assert_macros.svh
// assertion macros shared by the deframer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define WMD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define WMD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/wmd_pkg.sv
// types and constants of the wire message deframer
`default_nettype none
package wmd_pkg;

  localparam logic [15:0] HDR_BYTES     = 16'd8;
  localparam logic [1:0]  ALIGN_MASK    = 2'd3;
  localparam int          SIZE_SHIFT    = 16;
  localparam logic [15:0] MAX_BYTES_RST = 16'd4096;

  localparam logic [1:0] KIND_OBJECT = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ARG    = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  typedef struct packed {
    logic [1:0]  word_kind;
    logic [31:0] target_object;
    logic [15:0] request_opcode;
    logic [15:0] message_bytes;
    logic [13:0] argument_index;
    logic [31:0] word_value;
    logic        message_end;
    logic        framing_error;
  } result_t;

endpackage
`default_nettype wire

>>> src/wmd_if.sv
// request channels of the wire message deframer
`default_nettype none
interface wmd_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] stream_word;

  modport source (output valid, output stream_word, input ready);
  modport sink (input valid, input stream_word, output ready);
endinterface

interface wmd_tag_if;
  logic        valid;
  logic        ready;
  logic [1:0]  word_kind;
  logic [31:0] target_object;
  logic [15:0] request_opcode;
  logic [15:0] message_bytes;
  logic [13:0] argument_index;
  logic [31:0] word_value;
  logic        message_end;
  logic        framing_error;

  modport source (output valid, output word_kind, output target_object,
                  output request_opcode, output message_bytes, output argument_index,
                  output word_value, output message_end, output framing_error,
                  input ready);
  modport sink (input valid, input word_kind, input target_object,
                input request_opcode, input message_bytes, input argument_index,
                input word_value, input message_end, input framing_error,
                output ready);
endinterface
`default_nettype wire

>>> src/wmd_parser.sv
// framing state and per-word tagging logic
`default_nettype none
`include "assert_macros.svh"
module wmd_parser (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [31:0]     word,
  input  wire logic            cfg_we,
  input  wire logic [15:0]     cfg_data,
  output wmd_pkg::result_t     res
);
  import wmd_pkg::*;

  localparam logic [1:0] PH_OBJECT = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_ARGS   = 2'd2;

  logic [1:0]  phase;
  logic [1:0]  phase_next;
  logic [31:0] held_object;
  logic [31:0] held_object_next;
  logic [15:0] held_opcode;
  logic [15:0] held_opcode_next;
  logic [15:0] held_size;
  logic [15:0] held_size_next;
  logic [13:0] words_remaining;
  logic [13:0] words_remaining_next;
  logic [13:0] next_arg_index;
  logic [13:0] next_arg_index_next;
  logic        error_latched;
  logic        error_latched_next;
  logic [15:0] max_message_bytes;

  logic [15:0] size;
  logic [13:0] hdr_words;
  logic        size_bad;

  assign size      = word[SIZE_SHIFT +: 16];
  // (size - 8) / 4 once size is known to be at least 8
  assign hdr_words = size[15:2] - 14'd2;
  assign size_bad  = (size < HDR_BYTES) || ((size[1:0] & ALIGN_MASK) != 2'd0) ||
                     (size > max_message_bytes);

  always_comb begin
    phase_next           = phase;
    held_object_next     = held_object;
    held_opcode_next     = held_opcode;
    held_size_next       = held_size;
    words_remaining_next = words_remaining;
    next_arg_index_next  = next_arg_index;
    error_latched_next   = error_latched;
    res                  = '0;
    res.word_value       = word;
    if (error_latched) begin
      res.word_kind     = KIND_REJECT;
      res.framing_error = 1'b1;
    end else begin
      case (phase)
        PH_HEADER: begin
          if (size_bad) begin
            error_latched_next = 1'b1;
            res.word_kind      = KIND_REJECT;
            res.framing_error  = 1'b1;
          end else begin
            held_opcode_next     = word[15:0];
            held_size_next       = size;
            words_remaining_next = hdr_words;
            next_arg_index_next  = '0;
            phase_next           = (hdr_words == '0) ? PH_OBJECT : PH_ARGS;
            res.word_kind        = KIND_HEADER;
            res.target_object    = held_object;
            res.request_opcode   = word[15:0];
            res.message_bytes    = size;
            res.message_end      = (hdr_words == '0);
          end
        end
        PH_ARGS: begin
          res.word_kind        = KIND_ARG;
          res.target_object    = held_object;
          res.request_opcode   = held_opcode;
          res.message_bytes    = held_size;
          res.argument_index   = next_arg_index;
          res.message_end      = (words_remaining <= 14'd1);
          next_arg_index_next  = next_arg_index + 14'd1;
          words_remaining_next = words_remaining - 14'd1;
          if (words_remaining <= 14'd1) begin
            phase_next = PH_OBJECT;
          end
        end
        default: begin
          // object id word, unused phase code included
          held_object_next  = word;
          phase_next        = PH_HEADER;
          res.word_kind     = KIND_OBJECT;
          res.target_object = word;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_OBJECT;
      held_object       <= '0;
      held_opcode       <= '0;
      held_size         <= '0;
      words_remaining   <= '0;
      next_arg_index    <= '0;
      error_latched     <= 1'b0;
      max_message_bytes <= MAX_BYTES_RST;
    end else begin
      if (cfg_we) begin
        max_message_bytes <= cfg_data;
      end
      if (accept) begin
        phase           <= phase_next;
        held_object     <= held_object_next;
        held_opcode     <= held_opcode_next;
        held_size       <= held_size_next;
        words_remaining <= words_remaining_next;
        next_arg_index  <= next_arg_index_next;
        error_latched   <= error_latched_next;
      end
    end
  end

  `WMD_ASSERT(a_error_sticky, clk, rst, error_latched |=> error_latched, "framing error cleared")
  `WMD_ASSERT(a_args_pending, clk, rst, (phase == PH_ARGS) |-> (words_remaining != '0),
              "argument phase with no words left")
  `WMD_ASSERT(a_header_size_ok, clk, rst,
              (accept && res.word_kind == KIND_HEADER) |->
                (res.message_bytes[1:0] == 2'd0 && res.message_bytes >= HDR_BYTES &&
                 res.message_bytes <= max_message_bytes),
              "header tagged with a bad size")

endmodule
`default_nettype wire

>>> src/wmd_out_reg.sv
// result register between the tagging logic and the output channel
`default_nettype none
`include "assert_macros.svh"
module wmd_out_reg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire wmd_pkg::result_t in_res,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output wmd_pkg::result_t     out_res
);
  import wmd_pkg::*;

  logic    valid;
  result_t data;
  logic    load;

  // a new request can land in the same cycle the held one is taken
  assign in_ready  = !valid || out_ready;
  assign load      = in_valid && in_ready;
  assign out_valid = valid;
  assign out_res   = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= in_res;
    end
  end

  `WMD_ASSERT(a_no_overwrite, clk, rst, (valid && !out_ready) |-> !in_ready,
              "held result would be overwritten")
  `WMD_ASSERT(a_load_shows, clk, rst, load |=> valid, "loaded result not shown")
  `WMD_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !valid, "result valid after reset")

endmodule
`default_nettype wire

>>> src/wire_message_deframer.sv
// the tagged result of an accepted request is held in the result register before it is shown
// throughput: one word per clock while the output is not stalled; the result register refills while it is taken
// a stalled output holds one result and keeps the input ready low
// reset clears the framing state, the sticky error and the result valid,
// and sets the maximum message size back to 4096 bytes
`default_nettype none
module wire_message_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data,
  wmd_word_if.sink         words,
  wmd_tag_if.source        tags
);
  import wmd_pkg::*;

  result_t tag_res;
  result_t reg_res;
  logic    accept;

  assign accept = words.valid && words.ready;

  wmd_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .word     (words.stream_word),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .res      (tag_res)
  );

  wmd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (words.valid),
    .in_ready  (words.ready),
    .in_res    (tag_res),
    .out_valid (tags.valid),
    .out_ready (tags.ready),
    .out_res   (reg_res)
  );

  assign tags.word_kind      = reg_res.word_kind;
  assign tags.target_object  = reg_res.target_object;
  assign tags.request_opcode = reg_res.request_opcode;
  assign tags.message_bytes  = reg_res.message_bytes;
  assign tags.argument_index = reg_res.argument_index;
  assign tags.word_value     = reg_res.word_value;
  assign tags.message_end    = reg_res.message_end;
  assign tags.framing_error  = reg_res.framing_error;

endmodule
`default_nettype wire
